// File: rtl/gim_pkg.sv
// ----------------------------------------------------------------------------
// gim_pkg
// Shared types, register map and helpers of the greedy IoU detection matcher.
// ----------------------------------------------------------------------------
package gim_pkg;

   localparam int MAX_TRUTH_DEF  = 64;
   localparam int COUNT_BITS_DEF = 48;
   localparam int OUT_COUNT_W    = 48;
   localparam int SLOT_OUT_W     = 6;
   localparam int CSR_ADDR_W     = 3;
   localparam int CSR_DATA_W     = 32;
   localparam int THRESH_W       = 17;
   localparam logic [THRESH_W-1:0] THRESH_RESET = 17'd32768;

   // register index, taken from the word address
   localparam logic REG_MATCH_THRESHOLD = 1'b0;
   localparam logic REG_ANY_CLASS       = 1'b1;

   // operation codes of the request
   localparam logic [1:0] OP_LOAD  = 2'd0;
   localparam logic [1:0] OP_PRED  = 2'd1;
   localparam logic [1:0] OP_FRAME = 2'd2;

   typedef struct packed {
      logic [15:0] h;
      logic [15:0] w;
      logic [15:0] y;
      logic [15:0] x;
   } box_type;

   typedef struct packed {
      logic [7:0] obj_class;
      box_type    box;
   } truth_entry_type;

   // control handed from the sequencer to the scan datapath
   typedef struct packed {
      logic        clear;
      logic        any_class;
      logic [7:0]  obj_class;
      box_type     box;
      logic [31:0] area;
   } scan_ctrl_type;

   // length of the overlap of [p, p+pl) and [q, q+ql)
   function automatic logic [15:0] overlap_1d(logic [15:0] p, logic [15:0] pl,
                                              logic [15:0] q, logic [15:0] ql);
      logic [16:0] lo;
      logic [16:0] pe;
      logic [16:0] qe;
      logic [16:0] hi;
      logic [16:0] diff;
      lo   = (p > q) ? {1'b0, p} : {1'b0, q};
      pe   = {1'b0, p} + {1'b0, pl};
      qe   = {1'b0, q} + {1'b0, ql};
      hi   = (pe < qe) ? pe : qe;
      diff = hi - lo;
      return (hi > lo) ? diff[15:0] : 16'd0;
   endfunction

endpackage

// File: rtl/greedy_iou_detection_matcher.sv
// ----------------------------------------------------------------------------
// greedy_iou_detection_matcher
// Greedy IoU matching of predictions to ground truth with saturating
// true positive, false positive and false negative counts.
// ----------------------------------------------------------------------------
// One transaction at a time, one result transaction per request. A ground
// truth load or an unused code goes straight to the result. A prediction
// reads the table through one memory read port, one entry per cycle: the
// registered table read, a three-stage IoU pipe, then a threshold multiply
// and compare. End of frame reads the taken flags one per cycle.
// The result sits in an output register, so the next request is taken while
// an earlier result waits on rsp_stall. No clearing pass after reset: a load
// writes the taken flag with its entry and only loaded slots are ever read.
// Configuration: match_threshold at byte 0, any_class at byte 4.
// ----------------------------------------------------------------------------
module greedy_iou_detection_matcher #(
   parameter int MAX_TRUTH  = gim_pkg::MAX_TRUTH_DEF,
   parameter int COUNT_BITS = gim_pkg::COUNT_BITS_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic [1:0]                        req_operation,
   input  logic [7:0]                        req_obj_class,
   input  logic [15:0]                       req_box_x,
   input  logic [15:0]                       req_box_y,
   input  logic [15:0]                       req_box_w,
   input  logic [15:0]                       req_box_h,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic                              rsp_status,
   output logic                              rsp_matched,
   output logic [gim_pkg::SLOT_OUT_W-1:0]    rsp_matched_slot,
   output logic [gim_pkg::OUT_COUNT_W-1:0]   rsp_true_positives,
   output logic [gim_pkg::OUT_COUNT_W-1:0]   rsp_false_positives,
   output logic [gim_pkg::OUT_COUNT_W-1:0]   rsp_false_negatives,
   input  logic                              csr_psel,
   input  logic                              csr_penable,
   input  logic                              csr_pwrite,
   input  logic [gim_pkg::CSR_ADDR_W-1:0]    csr_paddr,
   input  logic [gim_pkg::CSR_DATA_W-1:0]    csr_pwdata,
   output logic [gim_pkg::CSR_DATA_W-1:0]    csr_prdata,
   output logic                              csr_pready
);

   localparam int IDX_W = (MAX_TRUTH > 1) ? $clog2(MAX_TRUTH) : 1;
   localparam int CNT_W = $clog2(MAX_TRUTH + 1);
   localparam logic [CNT_W-1:0]      CNT_MAX   = CNT_W'(MAX_TRUTH);
   localparam logic [COUNT_BITS-1:0] COUNT_TOP = {COUNT_BITS{1'b1}};

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN,
      ST_DECIDE,
      ST_CHECK,
      ST_FN,
      ST_FN_ADD,
      ST_DONE
   } state_type;

   state_type                      state_ff;
   logic [gim_pkg::THRESH_W-1:0]   thresh_ff;
   logic                           any_class_ff;
   logic [CNT_W-1:0]               count_ff;
   logic [CNT_W-1:0]               issue_ff;
   logic                           rd_valid_ff;
   logic [IDX_W-1:0]               rd_slot_ff;
   logic [CNT_W-1:0]               open_ff;
   logic [COUNT_BITS-1:0]          tp_ff;
   logic [COUNT_BITS-1:0]          fp_ff;
   logic [COUNT_BITS-1:0]          fn_ff;
   logic [7:0]                     pred_class_ff;
   gim_pkg::box_type               pred_box_ff;
   logic [31:0]                    pred_area_ff;
   logic [49:0]                    thresh_prod_ff;
   logic                           res_status_ff;
   logic                           res_matched_ff;
   logic [IDX_W-1:0]               res_slot_ff;
   logic                           rsp_valid_ff;
   logic                           rsp_status_ff;
   logic                           rsp_matched_ff;
   logic [gim_pkg::SLOT_OUT_W-1:0] rsp_slot_ff;
   logic [COUNT_BITS-1:0]          rsp_tp_ff;
   logic [COUNT_BITS-1:0]          rsp_fp_ff;
   logic [COUNT_BITS-1:0]          rsp_fn_ff;

   logic                     req_fire;
   logic                     cfg_write;
   logic                     rd_en;
   logic                     issue_done;
   logic                     rsp_load;
   logic                     tp_hit;
   logic                     entry_wr_en;
   logic                     taken_wr_en;
   logic [IDX_W-1:0]         taken_wr_addr;
   logic                     taken_wr_data;
   gim_pkg::truth_entry_type entry_wr_data;
   gim_pkg::truth_entry_type rd_entry;
   logic                     rd_taken;
   gim_pkg::scan_ctrl_type   scan_ctrl;
   logic                     scan_busy;
   logic                     scan_found;
   logic [31:0]              scan_inter;
   logic [32:0]              scan_union;
   logic [IDX_W-1:0]         scan_slot;
   logic [COUNT_BITS:0]      fn_sum;
   logic [COUNT_BITS-1:0]    tp_inc;
   logic [COUNT_BITS-1:0]    fp_inc;

   // Configuration port: zero wait states, decode on the word address.
   assign csr_pready = 1'b1;
   assign cfg_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_comb begin
      case (csr_paddr[2])
         gim_pkg::REG_MATCH_THRESHOLD:
            csr_prdata = gim_pkg::CSR_DATA_W'(thresh_ff);
         gim_pkg::REG_ANY_CLASS:
            csr_prdata = gim_pkg::CSR_DATA_W'(any_class_ff);
         default:
            csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         thresh_ff    <= gim_pkg::THRESH_RESET;
         any_class_ff <= 1'b0;
      end else if (cfg_write) begin
         case (csr_paddr[2])
            gim_pkg::REG_MATCH_THRESHOLD: thresh_ff <= csr_pwdata[gim_pkg::THRESH_W-1:0];
            gim_pkg::REG_ANY_CLASS:       any_class_ff <= csr_pwdata[0];
            default: ;
         endcase
      end
   end

   // Request side: take a new transaction only when the sequencer is idle.
   assign req_stall = (state_ff != ST_IDLE);
   assign req_fire  = req_valid && !req_stall;

   // Table writes: a load writes the entry with a cleared taken flag; a
   // match sets the taken flag of the winning slot.
   assign entry_wr_en   = req_fire && (req_operation == gim_pkg::OP_LOAD) &&
                          (count_ff < CNT_MAX);
   assign entry_wr_data = '{obj_class: req_obj_class,
                            box: '{h: req_box_h, w: req_box_w,
                                   y: req_box_y, x: req_box_x}};
   assign tp_hit        = scan_found &&
                          ({scan_inter, 16'd0} >= thresh_prod_ff[47:0]) &&
                          (thresh_prod_ff[49:48] == 2'd0);
   assign taken_wr_en   = entry_wr_en || ((state_ff == ST_CHECK) && tp_hit);
   assign taken_wr_addr = entry_wr_en ? count_ff[IDX_W-1:0] : scan_slot;
   assign taken_wr_data = !entry_wr_en;

   // Walk slots 0 .. count-1, one read a cycle.
   assign issue_done = (issue_ff == count_ff);
   assign rd_en      = ((state_ff == ST_SCAN) || (state_ff == ST_FN)) && !issue_done;

   gim_truth_store #(
      .MAX_TRUTH (MAX_TRUTH),
      .IDX_W     (IDX_W)
   ) u_store (
      .clock         (clock),
      .entry_wr_en   (entry_wr_en),
      .entry_wr_addr (count_ff[IDX_W-1:0]),
      .entry_wr_data (entry_wr_data),
      .taken_wr_en   (taken_wr_en),
      .taken_wr_addr (taken_wr_addr),
      .taken_wr_data (taken_wr_data),
      .rd_en         (rd_en),
      .rd_addr       (issue_ff[IDX_W-1:0]),
      .rd_entry      (rd_entry),
      .rd_taken      (rd_taken)
   );

   assign scan_ctrl = '{clear: req_fire, any_class: any_class_ff,
                        obj_class: pred_class_ff, box: pred_box_ff,
                        area: pred_area_ff};

   gim_iou_scan #(
      .MAX_TRUTH (MAX_TRUTH),
      .IDX_W     (IDX_W)
   ) u_scan (
      .clock      (clock),
      .reset      (reset),
      .ctrl       (scan_ctrl),
      .in_valid   (rd_valid_ff && (state_ff == ST_SCAN)),
      .in_entry   (rd_entry),
      .in_taken   (rd_taken),
      .in_slot    (rd_slot_ff),
      .busy       (scan_busy),
      .found      (scan_found),
      .best_inter (scan_inter),
      .best_union (scan_union),
      .best_slot  (scan_slot)
   );

   // Saturating counter updates.
   assign tp_inc = (tp_ff == COUNT_TOP) ? tp_ff : tp_ff + COUNT_BITS'(1);
   assign fp_inc = (fp_ff == COUNT_TOP) ? fp_ff : fp_ff + COUNT_BITS'(1);
   assign fn_sum = {1'b0, fn_ff} + (COUNT_BITS + 1)'(open_ff);

   // Output register: load when empty or when the held result leaves.
   assign rsp_load = (state_ff == ST_DONE) && (!rsp_valid_ff || !rsp_stall);

   always_ff @(posedge clock) begin
      if (req_fire) begin
         pred_class_ff <= req_obj_class;
         pred_box_ff   <= '{h: req_box_h, w: req_box_w, y: req_box_y, x: req_box_x};
         pred_area_ff  <= {16'd0, req_box_w} * {16'd0, req_box_h};
      end
      if (state_ff == ST_DECIDE) begin
         thresh_prod_ff <= {33'd0, thresh_ff} * {17'd0, scan_union};
      end
      rd_slot_ff <= issue_ff[IDX_W-1:0];
      if (rsp_load) begin
         rsp_status_ff  <= res_status_ff;
         rsp_matched_ff <= res_matched_ff;
         rsp_slot_ff    <= gim_pkg::SLOT_OUT_W'(res_slot_ff);
         rsp_tp_ff      <= tp_ff;
         rsp_fp_ff      <= fp_ff;
         rsp_fn_ff      <= fn_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         count_ff       <= '0;
         issue_ff       <= '0;
         rd_valid_ff    <= 1'b0;
         open_ff        <= '0;
         tp_ff          <= '0;
         fp_ff          <= '0;
         fn_ff          <= '0;
         res_status_ff  <= 1'b0;
         res_matched_ff <= 1'b0;
         res_slot_ff    <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         rd_valid_ff <= rd_en;
         if (rd_en) begin
            issue_ff <= issue_ff + CNT_W'(1);
         end
         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            ST_IDLE: begin
               if (req_fire) begin
                  res_status_ff  <= 1'b0;
                  res_matched_ff <= 1'b0;
                  res_slot_ff    <= '0;
                  issue_ff       <= '0;
                  open_ff        <= '0;
                  case (req_operation)
                     gim_pkg::OP_LOAD: begin
                        // full table: drop the box and flag it
                        if (entry_wr_en) begin
                           count_ff <= count_ff + CNT_W'(1);
                        end else begin
                           res_status_ff <= 1'b1;
                        end
                        state_ff <= ST_DONE;
                     end
                     gim_pkg::OP_PRED:  state_ff <= ST_SCAN;
                     gim_pkg::OP_FRAME: state_ff <= ST_FN;
                     default:           state_ff <= ST_DONE;
                  endcase
               end
            end
            ST_SCAN: begin
               // wait for the last read to leave the IoU pipe
               if (issue_done && !rd_valid_ff && !scan_busy) begin
                  state_ff <= ST_DECIDE;
               end
            end
            ST_DECIDE: begin
               state_ff <= ST_CHECK;
            end
            ST_CHECK: begin
               if (tp_hit) begin
                  tp_ff          <= tp_inc;
                  res_matched_ff <= 1'b1;
                  res_slot_ff    <= scan_slot;
               end else begin
                  fp_ff <= fp_inc;
               end
               state_ff <= ST_DONE;
            end
            ST_FN: begin
               if (rd_valid_ff && !rd_taken) begin
                  open_ff <= open_ff + CNT_W'(1);
               end
               if (issue_done && !rd_valid_ff) begin
                  state_ff <= ST_FN_ADD;
               end
            end
            ST_FN_ADD: begin
               fn_ff    <= fn_sum[COUNT_BITS] ? COUNT_TOP : fn_sum[COUNT_BITS-1:0];
               count_ff <= '0;
               state_ff <= ST_DONE;
            end
            ST_DONE: begin
               if (rsp_load) begin
                  state_ff <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_status          = rsp_status_ff;
   assign rsp_matched         = rsp_matched_ff;
   assign rsp_matched_slot    = rsp_slot_ff;
   assign rsp_true_positives  = gim_pkg::OUT_COUNT_W'(rsp_tp_ff);
   assign rsp_false_positives = gim_pkg::OUT_COUNT_W'(rsp_fp_ff);
   assign rsp_false_negatives = gim_pkg::OUT_COUNT_W'(rsp_fn_ff);

   // Table fill never passes its depth.
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_MAX)
      else $error("ground-truth count beyond table depth");

   // Reads stay inside the loaded slots.
   a_read_in_range: assert property (@(posedge clock) disable iff (reset)
      rd_en |-> (issue_ff < count_ff))
      else $error("table read beyond loaded entries");

   // A true positive needs a candidate from the scan.
   a_match_needs_found: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_CHECK && tp_hit) |-> scan_found)
      else $error("match without a candidate");

   // Counters only move up.
   a_tp_monotonic: assert property (@(posedge clock) disable iff (reset)
      1'b1 |=> (tp_ff >= $past(tp_ff)) && (fp_ff >= $past(fp_ff)) &&
               (fn_ff >= $past(fn_ff)))
      else $error("counter decreased");

endmodule

// File: rtl/gim_truth_store.sv
// ----------------------------------------------------------------------------
// gim_truth_store
// Ground-truth table: entry memory and taken-flag memory, one read address,
// registered read data.
// ----------------------------------------------------------------------------
module gim_truth_store #(
   parameter int MAX_TRUTH = gim_pkg::MAX_TRUTH_DEF,
   parameter int IDX_W     = (MAX_TRUTH > 1) ? $clog2(MAX_TRUTH) : 1
) (
   input  logic                      clock,
   input  logic                      entry_wr_en,
   input  logic [IDX_W-1:0]          entry_wr_addr,
   input  gim_pkg::truth_entry_type  entry_wr_data,
   input  logic                      taken_wr_en,
   input  logic [IDX_W-1:0]          taken_wr_addr,
   input  logic                      taken_wr_data,
   input  logic                      rd_en,
   input  logic [IDX_W-1:0]          rd_addr,
   output gim_pkg::truth_entry_type  rd_entry,
   output logic                      rd_taken
);

   gim_pkg::truth_entry_type entry_mem [MAX_TRUTH];
   logic                     taken_mem [MAX_TRUTH];
   gim_pkg::truth_entry_type rd_entry_ff;
   logic                     rd_taken_ff;

   always_ff @(posedge clock) begin
      if (entry_wr_en) begin
         entry_mem[entry_wr_addr] <= entry_wr_data;
      end
      if (rd_en) begin
         rd_entry_ff <= entry_mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (taken_wr_en) begin
         taken_mem[taken_wr_addr] <= taken_wr_data;
      end
      if (rd_en) begin
         rd_taken_ff <= taken_mem[rd_addr];
      end
   end

   assign rd_entry = rd_entry_ff;
   assign rd_taken = rd_taken_ff;

endmodule

// File: rtl/gim_iou_scan.sv
// ----------------------------------------------------------------------------
// gim_iou_scan
// IoU datapath: overlap, areas, union, then best-so-far update by exact
// cross-multiplied comparison. Takes one table entry per cycle.
// ----------------------------------------------------------------------------
module gim_iou_scan #(
   parameter int MAX_TRUTH = gim_pkg::MAX_TRUTH_DEF,
   parameter int IDX_W     = (MAX_TRUTH > 1) ? $clog2(MAX_TRUTH) : 1
) (
   input  logic                     clock,
   input  logic                     reset,
   input  gim_pkg::scan_ctrl_type   ctrl,
   input  logic                     in_valid,
   input  gim_pkg::truth_entry_type in_entry,
   input  logic                     in_taken,
   input  logic [IDX_W-1:0]         in_slot,
   output logic                     busy,
   output logic                     found,
   output logic [31:0]              best_inter,
   output logic [32:0]              best_union,
   output logic [IDX_W-1:0]         best_slot
);

   // stage 1: overlaps and eligibility
   logic             s1_valid_ff;
   logic             s1_ok_ff;
   logic [15:0]      s1_ox_ff;
   logic [15:0]      s1_oy_ff;
   logic [15:0]      s1_gw_ff;
   logic [15:0]      s1_gh_ff;
   logic [IDX_W-1:0] s1_slot_ff;
   // stage 2: intersection and entry area
   logic             s2_valid_ff;
   logic             s2_ok_ff;
   logic [31:0]      s2_inter_ff;
   logic [31:0]      s2_garea_ff;
   logic [IDX_W-1:0] s2_slot_ff;
   // stage 3: union and candidate flag
   logic             s3_valid_ff;
   logic             s3_cand_ff;
   logic [31:0]      s3_inter_ff;
   logic [32:0]      s3_union_ff;
   logic [IDX_W-1:0] s3_slot_ff;
   // best so far
   logic             found_ff;
   logic [31:0]      best_inter_ff;
   logic [32:0]      best_union_ff;
   logic [IDX_W-1:0] best_slot_ff;

   logic             s1_ok_in;
   logic [32:0]      union_in;
   logic [64:0]      lhs_prod;
   logic [64:0]      rhs_prod;
   logic             better;

   assign s1_ok_in = !in_taken &&
                     (ctrl.any_class || (in_entry.obj_class == ctrl.obj_class));
   assign union_in = {1'b0, ctrl.area} + {1'b0, s2_garea_ff} - {1'b0, s2_inter_ff};
   assign lhs_prod = {33'd0, s3_inter_ff} * {32'd0, best_union_ff};
   assign rhs_prod = {33'd0, best_inter_ff} * {32'd0, s3_union_ff};
   assign better   = s3_valid_ff && s3_cand_ff && (lhs_prod > rhs_prod);

   always_ff @(posedge clock) begin
      s1_ox_ff    <= gim_pkg::overlap_1d(ctrl.box.x, ctrl.box.w,
                                         in_entry.box.x, in_entry.box.w);
      s1_oy_ff    <= gim_pkg::overlap_1d(ctrl.box.y, ctrl.box.h,
                                         in_entry.box.y, in_entry.box.h);
      s1_gw_ff    <= in_entry.box.w;
      s1_gh_ff    <= in_entry.box.h;
      s1_ok_ff    <= s1_ok_in;
      s1_slot_ff  <= in_slot;
      s2_inter_ff <= {16'd0, s1_ox_ff} * {16'd0, s1_oy_ff};
      s2_garea_ff <= {16'd0, s1_gw_ff} * {16'd0, s1_gh_ff};
      s2_ok_ff    <= s1_ok_ff;
      s2_slot_ff  <= s1_slot_ff;
      s3_inter_ff <= s2_inter_ff;
      s3_union_ff <= union_in;
      s3_cand_ff  <= s2_ok_ff && (s2_inter_ff != 32'd0) && (union_in != 33'd0);
      s3_slot_ff  <= s2_slot_ff;
   end

   always_ff @(posedge clock) begin
      if (reset || ctrl.clear) begin
         s1_valid_ff   <= 1'b0;
         s2_valid_ff   <= 1'b0;
         s3_valid_ff   <= 1'b0;
         found_ff      <= 1'b0;
         best_inter_ff <= 32'd0;
         best_union_ff <= 33'd1;
         best_slot_ff  <= '0;
      end else begin
         s1_valid_ff <= in_valid;
         s2_valid_ff <= s1_valid_ff;
         s3_valid_ff <= s2_valid_ff;
         if (better) begin
            found_ff      <= 1'b1;
            best_inter_ff <= s3_inter_ff;
            best_union_ff <= s3_union_ff;
            best_slot_ff  <= s3_slot_ff;
         end
      end
   end

   assign busy       = s1_valid_ff || s2_valid_ff || s3_valid_ff;
   assign found      = found_ff;
   assign best_inter = best_inter_ff;
   assign best_union = best_union_ff;
   assign best_slot  = best_slot_ff;

endmodule

// File: bench/greedy_iou_detection_matcher_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// greedy_iou_detection_matcher_tb
// Self-checking bench: directed table plus random frames, each response
// compared against a behavioral matcher kept inside the bench.
// ----------------------------------------------------------------------------
module greedy_iou_detection_matcher_tb;

   localparam int TABLE_DEPTH = 64;
   localparam logic [47:0] COUNT_TOP = 48'hFFFF_FFFF_FFFF;
   localparam logic [1:0] OP_UNUSED = 2'd3;
   localparam int RANDOM_ITEMS = 2000;

   typedef struct {
      logic [1:0]  op;
      logic [7:0]  cls;
      logic [15:0] x, y, w, h;
   } request_type;

   typedef struct packed {
      logic        status;
      logic        matched;
      logic [5:0]  slot;
      logic [47:0] tp, fp, fn;
   } outcome_type;

   typedef struct {
      request_type req;
      logic        known;  // expected outcome typed in the table
      outcome_type want;
   } row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   logic [1:0]  req_operation = '0;
   logic [7:0]  req_obj_class = '0;
   logic [15:0] req_box_x = '0, req_box_y = '0, req_box_w = '0, req_box_h = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b1;
   logic rsp_status, rsp_matched;
   logic [5:0]  rsp_matched_slot;
   logic [47:0] rsp_true_positives, rsp_false_positives, rsp_false_negatives;
   logic csr_psel = 1'b0, csr_penable = 1'b0, csr_pwrite = 1'b0;
   logic [gim_pkg::CSR_ADDR_W-1:0] csr_paddr = '0;
   logic [gim_pkg::CSR_DATA_W-1:0] csr_pwdata = '0;
   logic [gim_pkg::CSR_DATA_W-1:0] csr_prdata;
   logic csr_pready;

   greedy_iou_detection_matcher uut (.*);

   always #1 clock = ~clock;

   // ------------------------------------------------------------------
   // Behavioral matcher state
   // ------------------------------------------------------------------
   gim_pkg::box_type gt_box   [TABLE_DEPTH];
   logic [7:0]       gt_class [TABLE_DEPTH];
   logic             gt_taken [TABLE_DEPTH];
   int               gt_fill;
   logic [47:0]      tp_count, fp_count, fn_count;
   logic [16:0]      iou_floor;
   logic             cross_class;

   outcome_type pending_q[$];
   int  errors = 0;
   bit  random_phase = 0;
   bit  rsp_idle_on = 1;

   function automatic logic [47:0] bump(logic [47:0] c, logic [47:0] n);
      logic [48:0] s;
      s = {1'b0, c} + {1'b0, n};
      return s[48] ? COUNT_TOP : s[47:0];
   endfunction

   function automatic logic [16:0] span(logic [15:0] p, logic [15:0] pl,
                                        logic [15:0] q, logic [15:0] ql);
      logic [16:0] lo, hi, pe, qe;
      lo = (p > q) ? {1'b0, p} : {1'b0, q};
      pe = {1'b0, p} + {1'b0, pl};
      qe = {1'b0, q} + {1'b0, ql};
      hi = (pe < qe) ? pe : qe;
      return (hi > lo) ? hi - lo : 17'd0;
   endfunction

   // apply one request to the matcher state, return what it yields
   function automatic outcome_type match_step(request_type r);
      outcome_type o;
      logic [63:0] area_p, inter, uni, best_i, best_u, ga;
      logic [127:0] lhs, rhs;
      int best, open;
      bit found;
      o = '{default: '0};
      if (r.op == gim_pkg::OP_LOAD) begin
         if (gt_fill < TABLE_DEPTH) begin
            gt_box[gt_fill] = '{h: r.h, w: r.w, y: r.y, x: r.x};
            gt_class[gt_fill] = r.cls;
            gt_taken[gt_fill] = 1'b0;
            gt_fill++;
         end else begin
            o.status = 1'b1;
         end
      end else if (r.op == gim_pkg::OP_PRED) begin
         area_p = 64'(r.w) * 64'(r.h);
         best_i = 0; best_u = 1; best = 0; found = 0;
         for (int i = 0; i < gt_fill; i++) begin
            if (gt_taken[i]) continue;
            if (!cross_class && gt_class[i] != r.cls) continue;
            inter = 64'(span(r.x, r.w, gt_box[i].x, gt_box[i].w)) *
                    64'(span(r.y, r.h, gt_box[i].y, gt_box[i].h));
            ga = 64'(gt_box[i].w) * 64'(gt_box[i].h);
            uni = area_p + ga - inter;
            if (inter == 0 || uni == 0) continue;
            lhs = 128'(inter) * 128'(best_u);
            rhs = 128'(best_i) * 128'(uni);
            if (lhs > rhs) begin
               best_i = inter; best_u = uni; best = i; found = 1;
            end
         end
         if (found && (128'(best_i) << 16) >= 128'(iou_floor) * 128'(best_u)) begin
            tp_count = bump(tp_count, 48'd1);
            gt_taken[best] = 1'b1;
            o.matched = 1'b1;
            o.slot = 6'(best);
         end else begin
            fp_count = bump(fp_count, 48'd1);
         end
      end else if (r.op == gim_pkg::OP_FRAME) begin
         open = 0;
         for (int i = 0; i < gt_fill; i++) if (!gt_taken[i]) open++;
         fn_count = bump(fn_count, 48'(open));
         gt_fill = 0;
      end
      o.tp = tp_count; o.fp = fp_count; o.fn = fn_count;
      return o;
   endfunction

   // ------------------------------------------------------------------
   // Driving helpers
   // ------------------------------------------------------------------
   function automatic int gap_len();
      if ($urandom_range(0, 3) == 0) return 0;          // no gap
      return ($urandom_range(0, 15) == 0) ? $urandom_range(10, 60)
                                          : $urandom_range(0, 2);
   endfunction

   task automatic csr_write(logic idx, logic [16:0] value);
      csr_psel <= 1'b1; csr_pwrite <= 1'b1; csr_penable <= 1'b0;
      csr_paddr <= gim_pkg::CSR_ADDR_W'({idx, 2'b00});
      csr_pwdata <= gim_pkg::CSR_DATA_W'(value);
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      csr_psel <= 1'b0; csr_penable <= 1'b0; csr_pwrite <= 1'b0;
      if (idx == gim_pkg::REG_MATCH_THRESHOLD) iou_floor = value;
      else cross_class = value[0];
   endtask

   // drain the pipe, then pause past the longest scan before touching CSRs
   task automatic settle();
      while (pending_q.size() != 0) @(posedge clock);
      repeat (100) @(posedge clock);
   endtask

   task automatic send(request_type r, logic known, outcome_type want);
      outcome_type o;
      int g;
      g = random_phase ? gap_len() : 0;
      if (g > 0) begin
         req_valid <= 1'b0;
         repeat (g) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_operation <= r.op; req_obj_class <= r.cls;
      req_box_x <= r.x; req_box_y <= r.y; req_box_w <= r.w; req_box_h <= r.h;
      do @(posedge clock); while (req_stall);
      o = match_step(r);
      if (known && o != want) begin
         $display("%0t table row disagrees with matcher: typed %p computed %p",
                  $time, want, o);
         errors++;
      end
      pending_q.insert(pending_q.size(), known ? want : o);
   endtask

   task automatic stop_sending();
      req_valid <= 1'b0;
      @(posedge clock);
   endtask

   // ------------------------------------------------------------------
   // Response side: random stalls, compare against oldest expectation
   // ------------------------------------------------------------------
   always @(posedge clock) begin
      outcome_type e;
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            if (pending_q.size() == 0) begin
               $display("%0t unexpected response transaction", $time);
               errors++;
            end else begin
               e = pending_q.pop_front();
               if (rsp_status !== e.status || rsp_matched !== e.matched ||
                   rsp_matched_slot !== e.slot || rsp_true_positives !== e.tp ||
                   rsp_false_positives !== e.fp || rsp_false_negatives !== e.fn) begin
                  $display("%0t mismatch: expected st=%0d m=%0d slot=%0d tp=%0d fp=%0d fn=%0d",
                           $time, e.status, e.matched, e.slot, e.tp, e.fp, e.fn);
                  $display("%0t          actual   st=%0d m=%0d slot=%0d tp=%0d fp=%0d fn=%0d",
                           $time, rsp_status, rsp_matched, rsp_matched_slot,
                           rsp_true_positives, rsp_false_positives,
                           rsp_false_negatives);
                  errors++;
               end
            end
         end
         // hold stall on a coin, with occasional long stretches
         if (!rsp_idle_on) rsp_stall <= 1'b0;
         else if ($urandom_range(0, 40) == 0) rsp_stall <= 1'b1;
         else if (rsp_stall && $urandom_range(0, 7) != 0 && $urandom_range(0, 1))
            rsp_stall <= 1'b1;
         else rsp_stall <= ($urandom_range(0, 3) == 0);
      end
   end

   // ------------------------------------------------------------------
   // Stimulus
   // ------------------------------------------------------------------
   function automatic request_type mk(logic [1:0] op, logic [7:0] c, logic [15:0] x,
                                      logic [15:0] y, logic [15:0] w, logic [15:0] h);
      request_type r;
      r.op = op; r.cls = c; r.x = x; r.y = y; r.w = w; r.h = h;
      return r;
   endfunction

   function automatic outcome_type res(logic st, logic m, logic [5:0] s,
                                       logic [47:0] tp, logic [47:0] fp, logic [47:0] fn);
      outcome_type o;
      o.status = st; o.matched = m; o.slot = s; o.tp = tp; o.fp = fp; o.fn = fn;
      return o;
   endfunction

   // random box, mostly small and clustered so overlaps happen
   function automatic request_type rand_box(logic [1:0] op, logic [7:0] cls);
      request_type r;
      r.op = op; r.cls = cls;
      if ($urandom_range(0, 9) == 0) begin
         r.x = 16'($urandom); r.y = 16'($urandom);
         r.w = 16'($urandom); r.h = 16'($urandom);
      end else begin
         r.x = 16'($urandom_range(0, 120)); r.y = 16'($urandom_range(0, 120));
         r.w = 16'($urandom_range(0, 60));  r.h = 16'($urandom_range(0, 60));
         if ($urandom_range(0, 7) == 0) begin
            r.x = 16'hFFFF - r.x; r.y = 16'hFFFF - r.y;
         end
      end
      return r;
   endfunction

   initial begin
      row_type rows[$];
      request_type r;
      outcome_type none;
      int n_gt, n_pred;
      logic [7:0] cls_pool;
      none = '{default: '0};
      gt_fill = 0; tp_count = 0; fp_count = 0; fn_count = 0;
      iou_floor = gim_pkg::THRESH_RESET; cross_class = 1'b0;

      // directed rows: expected outcome typed only where obvious
      rows.insert(rows.size(), '{mk(OP_UNUSED, 8'hFF, 16'hFFFF, 16'hFFFF, 16'hFFFF,
                                    16'hFFFF), 1, res(0, 0, 0, 0, 0, 0)});
      rows.insert(rows.size(), '{mk(gim_pkg::OP_PRED, 0, 0, 0, 10, 10), 1,
                                 res(0, 0, 0, 0, 1, 0)});
      rows.insert(rows.size(), '{mk(gim_pkg::OP_LOAD, 8'hFF, 16'hFFFF, 16'hFFFF,
                                    16'hFFFF, 16'hFFFF), 1, res(0, 0, 0, 0, 1, 0)});
      rows.insert(rows.size(), '{mk(gim_pkg::OP_LOAD, 3, 10, 10, 20, 20), 1,
                                 res(0, 0, 0, 0, 1, 0)});
      rows.insert(rows.size(), '{mk(gim_pkg::OP_LOAD, 3, 10, 10, 20, 20), 1,
                                 res(0, 0, 0, 0, 1, 0)});
      // exact copy matches the first equal entry
      rows.insert(rows.size(), '{mk(gim_pkg::OP_PRED, 3, 10, 10, 20, 20), 1,
                                 res(0, 1, 1, 1, 1, 0)});
      rows.insert(rows.size(), '{mk(gim_pkg::OP_PRED, 3, 10, 10, 20, 20), 1,
                                 res(0, 1, 2, 2, 1, 0)});
      rows.insert(rows.size(), '{mk(gim_pkg::OP_PRED, 8'hFF, 16'hFFFF, 16'hFFFF,
                                    16'hFFFF, 16'hFFFF), 0, none});
      rows.insert(rows.size(), '{mk(gim_pkg::OP_PRED, 3, 0, 0, 0, 0), 1,
                                 res(0, 0, 0, 3, 2, 0)});
      rows.insert(rows.size(), '{mk(gim_pkg::OP_PRED, 3, 15, 15, 20, 20), 0, none});
      rows.insert(rows.size(), '{mk(gim_pkg::OP_FRAME, 0, 0, 0, 0, 0), 0, none});
      rows.insert(rows.size(), '{mk(gim_pkg::OP_LOAD, 7, 0, 0, 100, 100), 0, none});
      // IoU exactly 0.5
      rows.insert(rows.size(), '{mk(gim_pkg::OP_PRED, 7, 0, 0, 50, 100), 0, none});
      // other class
      rows.insert(rows.size(), '{mk(gim_pkg::OP_PRED, 9, 0, 0, 100, 100), 0, none});
      rows.insert(rows.size(), '{mk(gim_pkg::OP_FRAME, 0, 0, 0, 0, 0), 0, none});

      // hold off until reset is released
      wait (!reset);
      @(posedge clock);

      foreach (rows[i]) send(rows[i].req, rows[i].known, rows[i].want);
      stop_sending();

      // full table: 64 loads then a dropped one
      settle();
      csr_write(gim_pkg::REG_ANY_CLASS, 17'd1);
      csr_write(gim_pkg::REG_MATCH_THRESHOLD, 17'd0);
      for (int i = 0; i < TABLE_DEPTH + 1; i++)
         send(mk(gim_pkg::OP_LOAD, 8'(i), 16'(i * 4), 0, 8, 8), 0, none);
      // no overlap, then an overlap with the last entries, threshold 0
      send(mk(gim_pkg::OP_PRED, 1, 16'd1000, 0, 4, 4), 0, none);
      send(mk(gim_pkg::OP_PRED, 1, 16'd250, 0, 4, 4), 0, none);
      send(mk(gim_pkg::OP_FRAME, 0, 0, 0, 0, 0), 0, none);
      stop_sending();
      settle();
      csr_write(gim_pkg::REG_MATCH_THRESHOLD, 17'd65537);          // unreachable
      send(mk(gim_pkg::OP_LOAD, 1, 5, 5, 9, 9), 0, none);
      send(mk(gim_pkg::OP_PRED, 1, 5, 5, 9, 9), 0, none);
      stop_sending();
      settle();
      csr_write(gim_pkg::REG_MATCH_THRESHOLD, 17'd65536);          // exactly one
      send(mk(gim_pkg::OP_PRED, 1, 5, 5, 9, 9), 0, none);
      send(mk(gim_pkg::OP_FRAME, 0, 0, 0, 0, 0), 0, none);
      stop_sending();

      // random frames in phases of changing configuration
      random_phase = 1;
      n_pred = 0;
      while (n_pred < RANDOM_ITEMS) begin
         settle();
         rsp_idle_on = ($urandom_range(0, 4) != 0);
         case ($urandom_range(0, 3))
            0: csr_write(gim_pkg::REG_MATCH_THRESHOLD, 17'($urandom_range(0, 65536)));
            1: csr_write(gim_pkg::REG_MATCH_THRESHOLD, 17'($urandom_range(20000, 45000)));
            2: csr_write(gim_pkg::REG_MATCH_THRESHOLD, 17'd131071);
            default: csr_write(gim_pkg::REG_MATCH_THRESHOLD, 17'd0);
         endcase
         csr_write(gim_pkg::REG_ANY_CLASS, 17'($urandom_range(0, 1)));
         for (int f = 0; f < 6; f++) begin
            cls_pool = $urandom_range(0, 3) == 0 ? 8'($urandom) : 8'($urandom_range(0, 3));
            n_gt = ($urandom_range(0, 15) == 0) ? $urandom_range(60, 70)
                                                : $urandom_range(0, 8);
            for (int i = 0; i < n_gt; i++) begin
               send(rand_box(gim_pkg::OP_LOAD, cls_pool ^ 8'($urandom_range(0, 1))),
                    0, none);
               n_pred++;
            end
            for (int i = 0; i < $urandom_range(0, 10); i++) begin
               r = rand_box(gim_pkg::OP_PRED, cls_pool ^ 8'($urandom_range(0, 1)));
               if ($urandom_range(0, 2) == 0 && gt_fill > 0) begin
                  // jitter x of a loaded box, take y and size from slot 0, so high IoU values come up
                  r.x = gt_box[$urandom_range(0, gt_fill - 1)].x + 16'($urandom_range(0, 3));
                  r.y = gt_box[0].y;
                  r.w = gt_box[0].w; r.h = gt_box[0].h;
               end
               if ($urandom_range(0, 30) == 0) r.op = OP_UNUSED;
               send(r, 0, none);
               n_pred++;
            end
            send(mk(gim_pkg::OP_FRAME, 8'($urandom), 16'($urandom), 16'($urandom),
                    16'($urandom), 16'($urandom)), 0, none);
            n_pred++;
         end
         stop_sending();
      end

      rsp_idle_on = 1'b0;
      settle();
      if (errors == 0) $display("[ OK ] regression clean");
      else $display("[FAIL] regression broken");
      $finish;
   end

   // release reset
   initial begin
      repeat (6) @(posedge clock);
      reset <= 1'b0;
   end

   // watchdog
   initial begin
      #8000000;
      $display("[FAIL] regression broken");
      $finish;
   end

endmodule
